// File: rtl/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg
// Shared constants, codes and types of the flow send scheduler.
// ----------------------------------------------------------------------------
package fss_pkg;

  localparam int FLOWS       = 16;
  localparam int COLLECTIVES = 16;
  localparam int RECEIVERS   = 1024;

  localparam int SLOT_W = $clog2(FLOWS);
  localparam int LEN_W  = $clog2(FLOWS) + 1;
  localparam int COLL_W = $clog2(COLLECTIVES);
  localparam int RX_W   = $clog2(RECEIVERS);
  localparam int ENT_W  = COLL_W + RX_W;

  // operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_REQ    = 2'd2;

  // scheduling modes
  localparam logic [1:0] MODE_PLAIN   = 2'd0;
  localparam logic [1:0] MODE_LIMITED = 2'd1;
  localparam logic [1:0] MODE_COLL    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_MAX_RX   = 2'd1;
  localparam logic [1:0] REG_FALLBACK = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_CMOD,
    ST_FINDC,
    ST_IMOD,
    ST_FINDP,
    ST_PICK1,
    ST_DONE
  } fss_state_t;

endpackage

// File: rtl/flow_send_scheduler_top.sv
// ----------------------------------------------------------------------------
// flow_send_scheduler_top
// Picks the next flow to send: plain list order, receiver-limited order or
// two-level round robin over collectives and their flows.
// ----------------------------------------------------------------------------
// Add, finish and plain requests go from the execute state to the result
// beat; mode 1 requests scan first (one slot table read per list entry),
// mode 2 requests scan and then run pointer and index reduction and searches.
// One item at a time; the next beat is taken while a result waits.
// Synchronous rst empties the list, clears receiver and pointer state and
// restores mode 2, four receivers, fallback on.
// ----------------------------------------------------------------------------
module flow_send_scheduler_top (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  // input beats
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // slot[3:0], collective[7:4], receiver[17:8], zero
  input  logic [1:0]  s_tuser,   // operation[1:0]
  // result beats
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // chosen_slot[3:0], zero
  output logic        m_tuser    // granted[0]
);
  import fss_pkg::*;

  fss_state_t state, state_next;

  // configuration
  logic [1:0] mode;
  logic [4:0] max_rx;
  logic       single_fb;

  // flow state
  logic [SLOT_W-1:0] list [FLOWS];
  logic [LEN_W-1:0]  len;
  logic [FLOWS-1:0]  live;
  logic [FLOWS-1:0]  rec_v, nv;
  logic [RX_W-1:0]   rec_rx [FLOWS];
  logic [RX_W-1:0]   nrx [FLOWS];
  logic [COLL_W-1:0] cptr;
  logic [SLOT_W-1:0] pcn [COLLECTIVES];

  // slot table memory: {collective, receiver}
  logic [ENT_W-1:0]  slot_mem [FLOWS];
  logic [ENT_W-1:0]  mem_q;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_raddr;

  // latched item
  logic [1:0]        op_q;
  logic [SLOT_W-1:0] slot_q;
  logic [COLL_W-1:0] coll_q;
  logic [RX_W-1:0]   rx_q;

  // scan results per list position
  logic [COLL_W-1:0] pos_co [FLOWS];
  logic [RX_W-1:0]   pos_rx [FLOWS];
  logic [FLOWS-1:0]  pos_in;
  logic [LEN_W-1:0]  size [COLLECTIVES];
  logic [LEN_W-1:0]  active;

  // sequencer registers
  logic [LEN_W-1:0]  cnt;
  logic              p_v;
  logic [SLOT_W-1:0] p_pos, p_slot;
  logic [COLL_W-1:0] cc, nth, csel;
  logic [SLOT_W-1:0] idx, seen, fp;
  logic              r_ok;
  logic [SLOT_W-1:0] r_slot;

  // combinational helpers
  logic [LEN_W-1:0]  present;
  logic [LEN_W-1:0]  rot_n;
  logic [SLOT_W-1:0] rot_list [FLOWS];
  logic [5:0]        rot_t [FLOWS];
  logic [SLOT_W-1:0] mtb_pos;
  logic [SLOT_W-1:0] mtb_list [FLOWS];
  logic [SLOT_W-1:0] fin_pos;
  logic [SLOT_W-1:0] pk_pos;
  logic              pk_found;
  logic [RX_W-1:0]   sc_rx;
  logic [COLL_W-1:0] sc_co;
  logic              sc_in, sc_first;
  logic              acc;
  logic              out_free;
  logic              plain_go;

  assign acc      = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign sc_rx    = mem_q[RX_W-1:0];
  assign sc_co    = mem_q[ENT_W-1:RX_W];

  // plain-order request served straight from the list head
  assign plain_go = (op_q == OP_REQ) && (mode != MODE_LIMITED) && (mode != MODE_COLL)
                    && (len != '0);

  // handshake outputs
  always_comb begin
    s_tready  = (state == ST_IDLE);
    cfg_ready = 1'b1;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (acc) state_next = ST_EXEC;
      ST_EXEC: begin
        if (op_q == OP_REQ && (mode == MODE_LIMITED || mode == MODE_COLL))
          state_next = ST_SCAN;
        else
          state_next = ST_DONE;
      end
      ST_SCAN: begin
        if (cnt == len) state_next = (mode == MODE_LIMITED) ? ST_PICK1 : ST_CMOD;
      end
      ST_CMOD: begin
        if (present != '0 && {1'b0, cptr} >= present)
          state_next = ST_CMOD;
        else if ((single_fb && present <= LEN_W'(1)) || present == '0)
          state_next = ST_DONE;
        else
          state_next = ST_FINDC;
      end
      ST_FINDC: if (size[cc] != '0 && nth == cptr) state_next = ST_IMOD;
      ST_IMOD:  if ({1'b0, idx} < size[csel]) state_next = ST_FINDP;
      ST_FINDP: if (pos_co[fp] == csel && seen == idx) state_next = ST_DONE;
      ST_PICK1: state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // count collectives present
  always_comb begin
    present = '0;
    for (int c = 0; c < COLLECTIVES; c++)
      present = present + LEN_W'(size[c] != '0);
  end

  // rotate the front rot_n entries to the back
  always_comb begin
    rot_n = LEN_W'(1);
    if (state == ST_PICK1) rot_n = LEN_W'(pk_pos) + LEN_W'(1);
    for (int i = 0; i < FLOWS; i++) begin
      rot_t[i] = 6'(i) + 6'(rot_n);
      if (rot_t[i] >= 6'(len)) rot_t[i] = rot_t[i] - 6'(len);
      rot_list[i] = list[rot_t[i][SLOT_W-1:0]];
    end
  end

  // position of the finished slot
  always_comb begin
    fin_pos = '0;
    for (int j = FLOWS - 1; j >= 0; j--)
      if (LEN_W'(j) < len && list[j] == slot_q) fin_pos = SLOT_W'(j);
  end

  // move one entry to the back of the list
  always_comb begin
    mtb_pos = (state == ST_FINDP) ? fp : fin_pos;
    for (int i = 0; i < FLOWS; i++) begin
      mtb_list[i] = list[i];
      if (LEN_W'(i) >= LEN_W'(mtb_pos) && LEN_W'(i) + LEN_W'(1) < len)
        mtb_list[i] = list[SLOT_W'(i + 1)];
      if (LEN_W'(i) + LEN_W'(1) == len)
        mtb_list[i] = list[mtb_pos];
    end
  end

  // receiver-limited pick position
  always_comb begin
    pk_found = 1'b0;
    pk_pos   = '0;
    if (len != '0 && active < max_rx) begin
      pk_found = 1'b1;
    end else begin
      for (int j = FLOWS - 1; j >= 0; j--)
        if (pos_in[j]) begin
          pk_found = 1'b1;
          pk_pos   = SLOT_W'(j);
        end
    end
  end

  // scan lookups: receiver already active, first time seen in this scan
  always_comb begin
    sc_in    = 1'b0;
    sc_first = 1'b1;
    for (int k = 0; k < FLOWS; k++)
      if (rec_v[k] && rec_rx[k] == sc_rx) sc_in = 1'b1;
    for (int j = 0; j < FLOWS; j++)
      if (SLOT_W'(j) < p_pos && pos_rx[j] == sc_rx) sc_first = 1'b0;
  end

  // slot table memory
  assign mem_we    = (state == ST_EXEC) && (op_q == OP_ADD) && !live[slot_q]
                     && (len < LEN_W'(FLOWS));
  assign mem_raddr = list[cnt[SLOT_W-1:0]];

  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[slot_q] <= {coll_q, rx_q};
    mem_q <= slot_mem[mem_raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      op_q   <= s_tuser;
      slot_q <= s_tdata[3:0];
      coll_q <= s_tdata[7:4];
      rx_q   <= s_tdata[17:8];
    end
    if (state == ST_SCAN && p_v) begin
      pos_co[p_pos] <= sc_co;
      pos_rx[p_pos] <= sc_rx;
      nrx[p_slot]   <= sc_rx;
    end
    if (state == ST_PICK1) begin
      for (int k = 0; k < FLOWS; k++) rec_rx[k] <= nrx[k];
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mode      <= MODE_COLL;
      max_rx    <= 5'd4;
      single_fb <= 1'b1;
      len       <= '0;
      live      <= '0;
      rec_v     <= '0;
      cptr      <= '0;
      for (int c = 0; c < COLLECTIVES; c++) pcn[c] <= '0;
      m_tvalid  <= 1'b0;
      p_v       <= 1'b0;
    end else begin
      state <= state_next;

      // config writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:     mode      <= cfg_data[1:0];
          REG_MAX_RX:   max_rx    <= cfg_data;
          REG_FALLBACK: single_fb <= cfg_data[0];
          default:      ;
        endcase
      end

      // result beat leaves; a new one is loaded in ST_DONE
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;

      case (state)
        ST_EXEC: begin
          r_ok   <= plain_go;
          r_slot <= plain_go ? list[0] : '0;
          cnt    <= '0;
          p_v    <= 1'b0;
          active <= '0;
          nv     <= '0;
          pos_in <= '0;
          for (int c = 0; c < COLLECTIVES; c++) size[c] <= '0;
          case (op_q)
            OP_ADD: begin
              if (mem_we) begin
                live[slot_q]           <= 1'b1;
                list[len[SLOT_W-1:0]]  <= slot_q;
                len                    <= len + LEN_W'(1);
              end
            end
            OP_FINISH: begin
              if (live[slot_q]) begin
                live[slot_q] <= 1'b0;
                for (int i = 0; i < FLOWS; i++) list[i] <= mtb_list[i];
                len <= len - LEN_W'(1);
              end
            end
            OP_REQ: begin
              if (plain_go) begin
                for (int i = 0; i < FLOWS; i++) list[i] <= rot_list[i];
              end
            end
            default: ;
          endcase
        end

        // walk the list, one slot table read per entry
        ST_SCAN: begin
          p_v    <= (cnt < len);
          p_pos  <= cnt[SLOT_W-1:0];
          p_slot <= list[cnt[SLOT_W-1:0]];
          if (cnt < len) cnt <= cnt + LEN_W'(1);
          if (p_v) begin
            size[sc_co]   <= size[sc_co] + LEN_W'(1);
            pos_in[p_pos] <= sc_in;
            nv[p_slot]    <= sc_in;
            if (sc_in && sc_first) active <= active + LEN_W'(1);
          end
          cc  <= '0;
          nth <= '0;
        end

        // reduce the collective pointer, or fall back
        ST_CMOD: begin
          if (present != '0 && {1'b0, cptr} >= present) begin
            cptr <= COLL_W'({1'b0, cptr} - present);
          end else if (single_fb && present <= LEN_W'(1)) begin
            if (len != '0) begin
              r_ok   <= 1'b1;
              r_slot <= list[0];
              for (int i = 0; i < FLOWS; i++) list[i] <= rot_list[i];
            end
          end
        end

        // find the pointed-to collective
        ST_FINDC: begin
          if (size[cc] != '0) begin
            if (nth == cptr) begin
              csel <= cc;
              idx  <= pcn[cc];
            end else begin
              nth <= nth + COLL_W'(1);
            end
          end
          cc <= cc + COLL_W'(1);
        end

        // reduce the flow index within the collective
        ST_IMOD: begin
          if ({1'b0, idx} >= size[csel]) begin
            idx <= SLOT_W'({1'b0, idx} - size[csel]);
          end else begin
            pcn[csel] <= ({1'b0, idx} + LEN_W'(1) == size[csel]) ? '0 : idx + SLOT_W'(1);
            cptr      <= ({1'b0, cptr} + LEN_W'(1) == present) ? '0 : cptr + COLL_W'(1);
            fp        <= '0;
            seen      <= '0;
          end
        end

        // find the flow and move it to the back
        ST_FINDP: begin
          if (pos_co[fp] == csel) begin
            if (seen == idx) begin
              r_ok   <= 1'b1;
              r_slot <= list[fp];
              for (int i = 0; i < FLOWS; i++) list[i] <= mtb_list[i];
            end else begin
              seen <= seen + SLOT_W'(1);
            end
          end
          fp <= fp + SLOT_W'(1);
        end

        // receiver-limited grant and active set rebuild
        ST_PICK1: begin
          rec_v <= pk_found ? (nv | (FLOWS'(1) << list[pk_pos])) : nv;
          if (pk_found) begin
            r_ok   <= 1'b1;
            r_slot <= list[pk_pos];
            for (int i = 0; i < FLOWS; i++) list[i] <= rot_list[i];
          end
        end

        ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= r_ok;
            m_tdata  <= {4'b0, r_slot};
          end
        end

        default: ;
      endcase
    end
  end

endmodule
